// ===== rtl/core/wsfd_pkg.sv =====
// Shared types for the WebSocket frame deframer: result kinds and the
// result record passed from the decoder to the output buffer. No dependencies.
package wsfd_pkg;

  typedef enum logic [1:0] {
    KIND_DATA     = 2'd0,
    KIND_EMPTY    = 2'd1,
    KIND_BAD_OP   = 2'd2,
    KIND_TOO_LONG = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload_byte;
    logic        last_of_frame;
  } result_t;

  localparam logic [3:0] OP_TEXT        = 4'h1;
  localparam logic [7:0] MASK_BIT       = 8'h80;
  localparam logic [7:0] OPCODE_MASK    = 8'h0f;
  localparam logic [7:0] LEN7_MASK      = 8'h7f;
  localparam logic [6:0] LEN7_EXT16     = 7'd126;
  localparam logic [6:0] LEN7_EXT64     = 7'd127;
  localparam logic [15:0] MAX_LEN_RESET = 16'd128;

  localparam logic [1:0] FORM_LEN7  = 2'd0;
  localparam logic [1:0] FORM_LEN16 = 2'd1;
  localparam logic [1:0] FORM_LEN64 = 2'd2;

endpackage

// ===== rtl/core/wsfd_decoder.sv =====
// Header decoder and payload unmasking for the WebSocket frame deframer.
// Holds all frame state and the size limit register. Depends on wsfd_pkg.
module wsfd_decoder
  import wsfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [15:0] cfg_data,
  input  logic        accept,
  input  logic [7:0]  data_byte,
  output logic        res_valid,
  output result_t     res
);

  logic [15:0] max_frame_len;
  logic [3:0]  header_index, header_index_next;
  logic [3:0]  frame_kind, frame_kind_next;
  logic        mask_present, mask_present_next;
  logic [1:0]  length_form, length_form_next;
  logic [63:0] frame_length, frame_length_next;
  logic [31:0] mask_key, mask_key_next;
  logic [15:0] payload_count, payload_count_next;
  logic        link_closed, link_closed_next;

  logic [3:0]  total_cur;
  logic [3:0]  total_sel;
  logic        check;
  logic [16:0] limit_rem;
  logic        too_long;
  logic [7:0]  key_byte;
  logic [16:0] count_inc;
  logic [6:0]  len7;

  function automatic logic [3:0] header_total(input logic [1:0] form, input logic mask);
    logic [3:0] ext;
    case (form)
      FORM_LEN16: ext = 4'd2;
      FORM_LEN64: ext = 4'd8;
      default:    ext = 4'd0;
    endcase
    header_total = 4'd2 + ext + (mask ? 4'd4 : 4'd0);
  endfunction

  assign total_cur = header_total(length_form, mask_present);
  assign len7      = data_byte[6:0] & LEN7_MASK[6:0];
  assign count_inc = {1'b0, payload_count} + 17'd1;

  always_comb begin
    case (payload_count[1:0])
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  // Size check uses the header size of the frame and the length as updated
  // by the byte just taken. The remaining room must not go negative.
  assign limit_rem = {1'b0, max_frame_len} - {13'd0, total_sel};
  assign too_long  = limit_rem[16] || (|frame_length_next[63:16]) ||
                     (frame_length_next[15:0] > limit_rem[15:0]);

  always_comb begin
    header_index_next  = header_index;
    frame_kind_next    = frame_kind;
    mask_present_next  = mask_present;
    length_form_next   = length_form;
    frame_length_next  = frame_length;
    mask_key_next      = mask_key;
    payload_count_next = payload_count;
    link_closed_next   = link_closed;
    total_sel          = total_cur;
    check              = 1'b0;
    res_valid          = 1'b0;
    res                = '{kind: KIND_DATA, payload_byte: 8'd0, last_of_frame: 1'b0};

    if (accept && !link_closed) begin
      if (header_index == 4'd0) begin
        frame_kind_next    = data_byte[3:0] & OPCODE_MASK[3:0];
        mask_present_next  = 1'b0;
        length_form_next   = FORM_LEN7;
        frame_length_next  = 64'd0;
        mask_key_next      = 32'd0;
        payload_count_next = 16'd0;
        header_index_next  = 4'd1;
      end else if (header_index == 4'd1) begin
        mask_present_next = (data_byte & MASK_BIT) != 8'd0;
        if (len7 == LEN7_EXT16) begin
          length_form_next = FORM_LEN16;
        end else if (len7 == LEN7_EXT64) begin
          length_form_next = FORM_LEN64;
        end else begin
          frame_length_next = {57'd0, len7};
        end
        header_index_next = 4'd2;
        total_sel = header_total(length_form_next, mask_present_next);
        check     = (total_sel == 4'd2);
      end else if (header_index < total_cur) begin
        if (header_index < (total_cur - (mask_present ? 4'd4 : 4'd0))) begin
          frame_length_next = {frame_length[55:0], data_byte};
        end else begin
          mask_key_next = {mask_key[23:0], data_byte};
        end
        header_index_next = header_index + 4'd1;
        check = (header_index_next == total_cur);
      end else begin
        payload_count_next = count_inc[15:0];
        res_valid          = 1'b1;
        res.kind           = KIND_DATA;
        res.payload_byte   = data_byte ^ key_byte;
        // An accepted frame's length fits in 16 bits, so 17 bits compare exactly.
        res.last_of_frame  = count_inc >= {1'b0, frame_length[15:0]};
        if (res.last_of_frame) begin
          header_index_next = 4'd0;
        end
      end

      if (check) begin
        if (too_long) begin
          link_closed_next = 1'b1;
          res_valid        = 1'b1;
          res.kind         = KIND_TOO_LONG;
        end else if (frame_kind != OP_TEXT) begin
          link_closed_next = 1'b1;
          res_valid        = 1'b1;
          res.kind         = KIND_BAD_OP;
        end else if (frame_length_next == 64'd0) begin
          header_index_next = 4'd0;
          res_valid         = 1'b1;
          res.kind          = KIND_EMPTY;
          res.last_of_frame = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_len <= MAX_LEN_RESET;
      header_index  <= 4'd0;
      frame_kind    <= 4'd0;
      mask_present  <= 1'b0;
      length_form   <= FORM_LEN7;
      frame_length  <= 64'd0;
      mask_key      <= 32'd0;
      payload_count <= 16'd0;
      link_closed   <= 1'b0;
    end else begin
      if (cfg_write) begin
        max_frame_len <= cfg_data;
      end
      header_index  <= header_index_next;
      frame_kind    <= frame_kind_next;
      mask_present  <= mask_present_next;
      length_form   <= length_form_next;
      frame_length  <= frame_length_next;
      mask_key      <= mask_key_next;
      payload_count <= payload_count_next;
      link_closed   <= link_closed_next;
    end
  end

endmodule

// ===== rtl/core/wsfd_out_buffer.sv =====
// Two-entry output buffer (result register plus skid entry) for the
// WebSocket frame deframer. Depends on wsfd_pkg.
module wsfd_out_buffer
  import wsfd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_data
);

  logic    main_valid;
  logic    skid_valid;
  result_t main_data;
  result_t skid_data;
  logic    out_fire;

  assign out_fire  = main_valid && !out_stall;
  assign out_valid = main_valid;
  assign out_data  = main_data;
  assign full      = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (push) begin
      // The upstream side only pushes while the skid entry is free.
      if (!main_valid || out_fire) begin
        main_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_fire) begin
      main_valid <= skid_valid;
      skid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      if (!main_valid || out_fire) begin
        main_data <= push_data;
      end else begin
        skid_data <= push_data;
      end
    end else if (out_fire && skid_valid) begin
      main_data <= skid_data;
    end
  end

`ifndef SYNTHESIS
  a_skid_needs_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid entry holds a result while the output register is empty");

  a_skid_fill_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(main_valid && out_stall && push))
    else $error("skid entry filled without a stalled output");

  a_held_when_stalled: assert property (@(posedge clk) disable iff (rst)
    (main_valid && out_stall) |=> main_valid)
    else $error("stalled result dropped");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && push) |-> 1'b0)
    else $error("result pushed into a full buffer");
`endif

endmodule

// ===== rtl/core/websocket_frame_deframer_unit.sv =====
// WebSocket frame deframer: decodes RFC 6455 frame headers from a byte
// stream and emits unmasked text payload bytes. The result of an accepted
// byte is registered in the output buffer's result register, or in its skid
// entry while the output stalls; one byte is accepted per cycle while the
// skid entry is free. Reset (rst, synchronous, active high) opens the link,
// clears frame state and loads a frame size limit of 128 bytes.
module websocket_frame_deframer_unit
  import wsfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Frame size limit register.
  input  logic        cfg_write,
  input  logic [15:0] cfg_data,
  // Received byte beats.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  // Result beats.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  payload_byte,
  output logic        last_of_frame
);

  logic    accept;
  logic    res_valid;
  result_t res;
  result_t out_data;
  logic    buf_full;

  // A beat is taken whenever the skid entry of the output buffer is free.
  // Once the output stalls, header bytes keep flowing, and the input stops
  // only after one more result has been parked in the skid entry.
  assign in_stall = buf_full;
  assign accept   = in_valid && !in_stall;

  // While the link is open, the decoder updates the frame state on every
  // accepted beat and forms at most one result: a payload byte, an empty-frame
  // marker, or an error that closes the link until reset.
  wsfd_decoder u_decoder (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .data_byte (data_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  // The result register and its skid entry decouple the two channels.
  wsfd_out_buffer u_out_buffer (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign kind          = out_data.kind;
  assign payload_byte  = out_data.payload_byte;
  assign last_of_frame = out_data.last_of_frame;

endmodule

// ===== verif/tb_websocket_frame_deframer_unit.sv =====
// Self-checking testbench for websocket_frame_deframer_unit: a directed table,
// random text frames and one closing error frame, checked against an in-bench
// frame decoder. Depends on wsfd_pkg and the deframer RTL only.
module tb_websocket_frame_deframer_unit;
  import wsfd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // A watchdog ends the run when no beat moves on either side for this long.
  localparam int WATCHDOG_LIMIT = 2000;
  // Idle cycles before a limit write and after the last result.
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES = 80;

  typedef enum logic {ROW_BYTE, ROW_LIMIT} row_op_t;

  // One directed row: either a stream byte or a new frame size limit. When typed
  // is set, the result of that byte is given in the row instead of predicted.
  typedef struct packed {
    row_op_t     op;
    logic [15:0] value;
    logic        typed;
    kind_t       kind;
    logic [7:0]  pay;
    logic        last;
  } step_t;

  localparam step_t DIRECTED_STEPS [25] = '{
    '{ROW_BYTE,  16'h0081, 1'b0, KIND_DATA,  8'h00, 1'b0}, // FIN plus text opcode
    '{ROW_BYTE,  16'h0000, 1'b1, KIND_EMPTY, 8'h00, 1'b1}, // empty text frame
    '{ROW_BYTE,  16'h0001, 1'b0, KIND_DATA,  8'h00, 1'b0}, // FIN clear, still text
    '{ROW_BYTE,  16'h0001, 1'b0, KIND_DATA,  8'h00, 1'b0}, // unmasked, one byte
    '{ROW_BYTE,  16'h00ff, 1'b1, KIND_DATA,  8'hff, 1'b1},
    '{ROW_BYTE,  16'h00f1, 1'b0, KIND_DATA,  8'h00, 1'b0}, // reserved bits set
    '{ROW_BYTE,  16'h0083, 1'b0, KIND_DATA,  8'h00, 1'b0}, // masked, three bytes
    '{ROW_BYTE,  16'h00ff, 1'b0, KIND_DATA,  8'h00, 1'b0}, // masking key
    '{ROW_BYTE,  16'h0000, 1'b0, KIND_DATA,  8'h00, 1'b0},
    '{ROW_BYTE,  16'h00a5, 1'b0, KIND_DATA,  8'h00, 1'b0},
    '{ROW_BYTE,  16'h005a, 1'b0, KIND_DATA,  8'h00, 1'b0},
    '{ROW_BYTE,  16'h0000, 1'b0, KIND_DATA,  8'h00, 1'b0}, // payload
    '{ROW_BYTE,  16'h005a, 1'b0, KIND_DATA,  8'h00, 1'b0},
    '{ROW_BYTE,  16'h00ff, 1'b0, KIND_DATA,  8'h00, 1'b0},
    '{ROW_LIMIT, 16'd2,    1'b0, KIND_DATA,  8'h00, 1'b0}, // smallest legal limit
    '{ROW_BYTE,  16'h0081, 1'b0, KIND_DATA,  8'h00, 1'b0},
    '{ROW_BYTE,  16'h0000, 1'b1, KIND_EMPTY, 8'h00, 1'b1}, // header alone fits exactly
    '{ROW_LIMIT, 16'hffff, 1'b0, KIND_DATA,  8'h00, 1'b0}, // largest limit
    '{ROW_BYTE,  16'h0081, 1'b0, KIND_DATA,  8'h00, 1'b0},
    '{ROW_BYTE,  16'h007e, 1'b0, KIND_DATA,  8'h00, 1'b0}, // 16-bit length form
    '{ROW_BYTE,  16'h0000, 1'b0, KIND_DATA,  8'h00, 1'b0},
    '{ROW_LIMIT, 16'd6,    1'b0, KIND_DATA,  8'h00, 1'b0}, // limit changed mid-header
    '{ROW_BYTE,  16'h0002, 1'b0, KIND_DATA,  8'h00, 1'b0}, // short length, not minimal
    '{ROW_BYTE,  16'h00ab, 1'b0, KIND_DATA,  8'h00, 1'b0},
    '{ROW_BYTE,  16'h00cd, 1'b0, KIND_DATA,  8'h00, 1'b0}
  };

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  kind;
  logic [7:0]  payload_byte;
  logic        last_of_frame;

  // Travels with each byte beat: a result fixed by the directed table.
  logic        typed_valid;
  result_t     typed_result;

  // Decoder state kept by the bench, mirroring what the block should hold.
  logic [15:0] limit_model;
  logic [3:0]  hdr_pos;
  logic [3:0]  op_code;
  logic        masked;
  logic [1:0]  len_form;
  logic [63:0] pay_len;
  logic [31:0] key;
  logic [15:0] pay_sent;
  logic        closed;

  result_t     expected_results [$];
  int          fail_count;
  int          bytes_sent;
  int          quiet_cycles;

  // Knobs set by the stimulus, some of them read by the receiver process.
  bit          tx_quiet;
  bit          rx_quiet;
  bit          calm;
  bit          hold_req;

  websocket_frame_deframer_unit uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .data_byte     (data_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .kind          (kind),
    .payload_byte  (payload_byte),
    .last_of_frame (last_of_frame)
  );

  always #5 clk = ~clk;

  // Header size of the frame being decoded: two fixed bytes, the extended
  // length bytes of its form, and the masking key when the mask bit is set.
  function automatic int unsigned header_bytes();
    return 2 + ((len_form == FORM_LEN16) ? 2 : (len_form == FORM_LEN64) ? 8 : 0) +
           (masked ? 4 : 0);
  endfunction

  // Runs once the last header byte is in. The size test comes first, so a
  // non-text frame that is also too long reports as too long. The sum of
  // header and payload is compared without any wrap.
  function automatic logic judge_header(output result_t r);
    int unsigned hsize;
    logic        too_long;
    hsize = header_bytes();
    r = '0;
    if (hsize > limit_model) too_long = 1'b1;
    else too_long = pay_len > 64'(limit_model - hsize);
    if (too_long) begin
      closed = 1'b1;
      r.kind = KIND_TOO_LONG;
      return 1'b1;
    end
    if (op_code != OP_TEXT) begin
      closed = 1'b1;
      r.kind = KIND_BAD_OP;
      return 1'b1;
    end
    if (pay_len == 64'd0) begin
      hdr_pos = 4'd0;
      r.kind = KIND_EMPTY;
      r.last_of_frame = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advances the decoder by one stream byte and tells whether a result comes out.
  function automatic logic deframe_byte(input logic [7:0] b, output result_t r);
    int unsigned hsize;
    logic [7:0]  key_byte;
    r = '0;
    if (closed) return 1'b0;
    if (hdr_pos == 4'd0) begin
      op_code = b[3:0];
      masked = 1'b0;
      len_form = FORM_LEN7;
      pay_len = '0;
      key = '0;
      pay_sent = '0;
      hdr_pos = 4'd1;
      return 1'b0;
    end
    if (hdr_pos == 4'd1) begin
      masked = b[7];
      if (b[6:0] == LEN7_EXT16) len_form = FORM_LEN16;
      else if (b[6:0] == LEN7_EXT64) len_form = FORM_LEN64;
      else pay_len = 64'(b[6:0]);
      hdr_pos = 4'd2;
      if (header_bytes() == 2) return judge_header(r);
      return 1'b0;
    end
    hsize = header_bytes();
    if (hdr_pos < hsize) begin
      // Extended length bytes arrive big-endian, then the key bytes.
      if (hdr_pos < hsize - (masked ? 4 : 0)) pay_len = {pay_len[55:0], b};
      else key = {key[23:0], b};
      hdr_pos = hdr_pos + 4'd1;
      if (hdr_pos == hsize) return judge_header(r);
      return 1'b0;
    end
    key_byte = key[31 - 8 * pay_sent[1:0] -: 8];
    pay_sent = pay_sent + 16'd1;
    r.kind = KIND_DATA;
    r.payload_byte = b ^ key_byte;
    r.last_of_frame = {48'd0, pay_sent} >= pay_len;
    if (r.last_of_frame) hdr_pos = 4'd0;
    return 1'b1;
  endfunction

  // Everything is sampled at the rising edge; the bench drives on the falling
  // edge, so nothing here races with its own stimulus.
  always @(posedge clk) begin : track
    result_t predicted;
    result_t want;
    logic    produced;
    if (rst) begin
      limit_model = MAX_LEN_RESET;
      hdr_pos = '0;
      op_code = '0;
      masked = 1'b0;
      len_form = FORM_LEN7;
      pay_len = '0;
      key = '0;
      pay_sent = '0;
      closed = 1'b0;
    end else begin
      if (cfg_write) limit_model = cfg_data;
      // The input side is handled first, so the expectation of a byte taken in
      // this cycle is queued before that cycle's output beat is checked.
      if (in_valid && !in_stall) begin
        produced = deframe_byte(data_byte, predicted);
        if (typed_valid) expected_results.push_back(typed_result);
        else if (produced) expected_results.push_back(predicted);
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result beat: kind %0d payload_byte %02h last_of_frame %0d",
                 kind, payload_byte, last_of_frame);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, kind);
            fail_count++;
          end
          if (payload_byte !== want.payload_byte) begin
            $error("payload_byte: expected %02h, got %02h", want.payload_byte, payload_byte);
            fail_count++;
          end
          if (last_of_frame !== want.last_of_frame) begin
            $error("last_of_frame: expected %0d, got %0d", want.last_of_frame, last_of_frame);
            fail_count++;
          end
        end
      end
    end
  end

  // Watchdog: counts cycles in which no beat moves on either channel.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver. Random stall bursts unless told to stay quiet, and on request one
  // long hold so that the block backs up into its input.
  initial begin : receiver
    int stall_left;
    out_stall = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else if (!calm && !rx_quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 10);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Offers one byte beat and returns at the edge where it is taken. Valid stays
  // high after it, so back-to-back calls stream one byte per cycle while the
  // input is not stalled; an optional random gap drops valid first.
  task automatic send_byte(input logic [7:0] b, input logic typed = 1'b0,
                           input result_t given = '0);
    int gap;
    if (!calm && !tx_quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    data_byte <= b;
    typed_valid <= typed;
    typed_result <= given;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  // The limit is only written once the output has drained, plus a few cycles
  // for any byte that is still inside the block without a result of its own.
  task automatic write_limit(input logic [15:0] lim);
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data <= lim;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Sends one frame: opcode byte with random FIN and reserved bits, length
  // byte, extended length big-endian, random key when masked, then npay random
  // payload bytes (npay may differ from len when the frame is meant to fail).
  task automatic send_frame(input logic [63:0] len, input logic [1:0] form, input logic mask,
                            input logic [3:0] op, input int npay);
    logic [6:0] len7;
    int         ext;
    len7 = (form == FORM_LEN16) ? LEN7_EXT16 : (form == FORM_LEN64) ? LEN7_EXT64 : len[6:0];
    ext = (form == FORM_LEN16) ? 2 : (form == FORM_LEN64) ? 8 : 0;
    send_byte({4'($urandom), op});
    send_byte({mask, len7});
    for (int i = ext - 1; i >= 0; i--) send_byte(len[8 * i +: 8]);
    if (mask) repeat (4) send_byte(8'($urandom));
    repeat (npay) send_byte(8'($urandom));
  endtask

  // A run of well-formed text frames under one limit. Lengths stay inside the
  // limit, mostly short, sometimes right at the boundary, and the idling mode of
  // both sides is redrawn for every frame.
  task automatic run_phase(input logic [15:0] lim, input int budget, input int big_cap);
    int         start;
    int         cap;
    int         room;
    int         hsize;
    int         len;
    int         pick;
    logic [1:0] form;
    logic       mask;
    write_limit(lim);
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      cap = ($urandom_range(0, 9) == 0) ? big_cap : 24;
      pick = $urandom_range(0, 7);
      form = (pick < 5) ? FORM_LEN7 : (pick < 7) ? FORM_LEN16 : FORM_LEN64;
      mask = 1'($urandom);
      hsize = 2 + ((form == FORM_LEN16) ? 2 : (form == FORM_LEN64) ? 8 : 0) + (mask ? 4 : 0);
      if (hsize > int'(limit_model)) begin
        form = FORM_LEN7;
        mask = 1'b0;
        hsize = 2;
      end
      room = int'(limit_model) - hsize;
      if (form == FORM_LEN7 && room > 125) room = 125;
      if (room > cap) room = cap;
      len = ($urandom_range(0, 7) == 0) ? room : $urandom_range(0, room);
      send_frame(64'(len), form, mask, OP_TEXT, len);
    end
  endtask

  initial begin : stimulus
    step_t      step;
    result_t    given;
    logic [3:0] bad_op;
    logic [15:0] lim;
    clk = 1'b0;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    data_byte = '0;
    typed_valid = 1'b0;
    typed_result = '0;
    fail_count = 0;
    bytes_sent = 0;
    quiet_cycles = 0;
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    calm = 1'b0;
    hold_req = 1'b0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // Directed table: extremes, the 16-bit length extension, masking, reserved
    // and FIN bits, the smallest limit and a limit change inside a header.
    foreach (DIRECTED_STEPS[i]) begin
      step = DIRECTED_STEPS[i];
      if (step.op == ROW_LIMIT) begin
        write_limit(step.value);
      end else begin
        given.kind = step.kind;
        given.payload_byte = step.pay;
        given.last_of_frame = step.last;
        send_byte(step.value[7:0], step.typed, given);
      end
    end

    // Random text frames under several limits. Any error closes the link for
    // the rest of the run, so every frame here is kept legal.
    run_phase(16'hffff, 60, 300);

    // Long receiver hold during a long frame while the sender keeps offering,
    // so the block fills up and stalls its input.
    tx_quiet = 1'b1;
    hold_req = 1'b1;
    send_frame(64'd200, FORM_LEN16, 1'b1, OP_TEXT, 200);

    run_phase(16'd2, 30, 0);
    run_phase(MAX_LEN_RESET, 90, 125);
    run_phase(16'($urandom_range(3, 40)), 80, 300);

    // Last part of the run: no idling on either side.
    calm = 1'b1;
    run_phase(16'($urandom_range(2, 65535)), 90, 300);

    // Closing: one error per run, since the link stays closed until reset.
    // The bytes that follow the error must all be ignored.
    bad_op = 4'($urandom_range(0, 14));
    if (bad_op >= OP_TEXT) bad_op = bad_op + 4'd1;
    case ($urandom_range(0, 4))
      0: begin
        // Non-text opcode (continuation included) of legal size.
        write_limit(MAX_LEN_RESET);
        send_frame(64'd5, FORM_LEN7, 1'($urandom), bad_op, 20);
      end
      1: begin
        // Non-text and too long at once: the size error wins.
        write_limit(MAX_LEN_RESET);
        send_frame(64'd125, FORM_LEN7, 1'b1, bad_op, 20);
      end
      2: begin
        // 64-bit length with the top bit set must not wrap into a small size.
        write_limit(16'hffff);
        send_frame({1'b1, 31'($urandom), 32'($urandom)}, FORM_LEN64, 1'($urandom),
                   OP_TEXT, 20);
      end
      3: begin
        // A limit below the two header bytes rejects even an empty frame.
        write_limit(16'($urandom_range(0, 1)));
        send_frame(64'd0, FORM_LEN7, 1'b0, OP_TEXT, 20);
      end
      default: begin
        // One byte past the limit.
        lim = 16'($urandom_range(14, 2000));
        write_limit(lim);
        send_frame(64'(lim - 16'd3), FORM_LEN16, 1'b0, OP_TEXT, 20);
      end
    endcase

    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/wsfd_pkg.sv
rtl/core/wsfd_decoder.sv
rtl/core/wsfd_out_buffer.sv
rtl/core/websocket_frame_deframer_unit.sv
verif/tb_websocket_frame_deframer_unit.sv
